[hw/rtl/boxcar_moving_average_unit_macros.svh]
// Assertion macros shared by the boxcar moving average RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef BOXCAR_MOVING_AVERAGE_UNIT_MACROS_SVH
`define BOXCAR_MOVING_AVERAGE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BMA_ASSERT_IMP(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bma: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define BMA_ASSERT_NXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bma: next-cycle check failed");

`endif

[hw/rtl/bma_pkg.sv]
// Package for the boxcar moving average unit: defaults, field widths, state types.
// Depends on nothing; used by the interfaces, the top and the front, queue and back parts.
package bma_pkg;

	// Default module parameters
	localparam int WINDOW_DEF      = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed result field widths
	localparam int FRAC_BITS = 8;
	localparam int AVG_W     = 24;
	localparam int SUM_OUT_W = 20;
	localparam int CNT_OUT_W = 5;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		F_IDLE,
		F_UPDATE
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_HOLD
	} back_state_t;

endpackage

[hw/rtl/bma_if.sv]
// Request and result channel interfaces for the boxcar moving average unit.
// Depends on bma_pkg for default and field widths.
interface bma_in_if #(
	parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, command, sample, input ready);
	modport sink   (input valid, command, sample, output ready);
endinterface

interface bma_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bma_pkg::AVG_W-1:0]      average;
	logic signed [bma_pkg::SUM_OUT_W-1:0]  window_sum;
	logic        [bma_pkg::CNT_OUT_W-1:0]  fill_count;
	logic                                  window_full;

	modport source (output valid, average, window_sum, fill_count, window_full, input ready);
	modport sink   (input valid, average, window_sum, fill_count, window_full, output ready);
endinterface

[hw/rtl/boxcar_moving_average_unit.sv]
// The back-end restoring divider, one quotient bit a cycle, divides the window sum (SUMW =
// SAMPLE_BITS + clog2(WINDOW) bits) and takes a new entry once its result is registered.
// The front takes a request, then updates the window and pushes into a two-entry queue
// before it takes the next, so it accepts requests while the queue has room and the back divides.
// Reset: arst_n clears sum, count, pointer and handshake state at once; the sample ring
// is not cleared, since an entry's old value is used only after it has been written.
module boxcar_moving_average_unit #(
	parameter int WINDOW      = bma_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bma_in_if.sink    request,
	bma_out_if.source result
);

	localparam int SUMW = SAMPLE_BITS + $clog2(WINDOW);
	localparam int CW   = $clog2(WINDOW + 1);

	logic                   push;
	logic signed [SUMW-1:0] push_sum;
	logic [CW-1:0]          push_cnt;
	logic                   q_full;
	logic                   q_valid;
	logic                   pop;
	logic [SUMW+CW-1:0]     q_data;

	// Accept and update the window
	bma_front #(
		.WINDOW     (WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUMW       (SUMW),
		.CW         (CW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.q_full  (q_full),
		.push    (push),
		.push_sum(push_sum),
		.push_cnt(push_cnt)
	);

	// Decouple front and back
	bma_queue #(
		.WIDTH(SUMW + CW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   ({push_sum, push_cnt}),
		.full  (q_full),
		.pop   (pop),
		.valid (q_valid),
		.dout  (q_data)
	);

	// Divide and deliver
	bma_back #(
		.WINDOW(WINDOW),
		.SUMW  (SUMW),
		.CW    (CW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_sum  (q_data[SUMW+CW-1:CW]),
		.q_cnt  (q_data[CW-1:0]),
		.pop    (pop),
		.result (result)
	);

endmodule

[hw/rtl/bma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, register one read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/bma_front.sv]
// Front part: accepts requests, keeps the sample ring, pointer, count and running sum.
// Depends on bma_pkg, bma_if, bma_ram and the assertion macro header.
`include "boxcar_moving_average_unit_macros.svh"

module bma_front #(
	parameter int WINDOW      = bma_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF,
	parameter int SUMW        = SAMPLE_BITS + $clog2(WINDOW),
	parameter int CW          = $clog2(WINDOW + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	bma_in_if.sink                 request,
	input  logic                   q_full,
	output logic                   push,
	output logic signed [SUMW-1:0] push_sum,
	output logic [CW-1:0]          push_cnt
);

	localparam int PW = $clog2(WINDOW);

	bma_pkg::front_state_t state_q, state_d;

	logic                          cmd_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [PW-1:0]                 wp_q;
	logic [CW-1:0]                 cnt_q;
	logic signed [SUMW-1:0]        sum_q;

	logic [SAMPLE_BITS-1:0]        old_sample;
	logic signed [SUMW-1:0]        x_ext;
	logic signed [SUMW-1:0]        old_ext;
	logic signed [SUMW-1:0]        next_sum;
	logic [CW-1:0]                 next_cnt;
	logic [PW-1:0]                 next_wp;
	logic                          filling;
	logic                          accept;

	assign accept = request.valid && request.ready;

	// Ring of past samples, read at the pointer on accept, written back in update
	bma_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (push && !cmd_s1),
		.waddr(wp_q),
		.wdata(sample_s1),
		.re   (accept && !request.command),
		.raddr(wp_q),
		.rdata(old_sample)
	);

	// Sign-extend new and leaving samples to the sum width
	assign x_ext   = {{(SUMW - SAMPLE_BITS){sample_s1[SAMPLE_BITS-1]}}, sample_s1};
	assign old_ext = {{(SUMW - SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
	assign filling = cnt_q < CW'(WINDOW);

	// Add the new sample, drop the overwritten one once the ring is full
	assign next_sum = filling ? (sum_q + x_ext) : (sum_q + x_ext - old_ext);
	assign next_cnt = filling ? (cnt_q + 1'b1) : cnt_q;
	assign next_wp  = (wp_q == PW'(WINDOW - 1)) ? '0 : (wp_q + 1'b1);

	// Next state and handshake
	always_comb begin
		state_d       = state_q;
		request.ready = 1'b0;
		push          = 1'b0;
		case (state_q)
			bma_pkg::F_IDLE: begin
				request.ready = !q_full;
				if (accept) begin
					state_d = bma_pkg::F_UPDATE;
				end
			end
			bma_pkg::F_UPDATE: begin
				push    = 1'b1;
				state_d = bma_pkg::F_IDLE;
			end
			default: begin
				state_d = bma_pkg::F_IDLE;
			end
		endcase
	end

	assign push_sum = cmd_s1 ? '0 : next_sum;
	assign push_cnt = cmd_s1 ? '0 : next_cnt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bma_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window state: clear on command, advance on push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			cnt_q <= '0;
			sum_q <= '0;
		end else if (push) begin
			if (cmd_s1) begin
				wp_q  <= '0;
				cnt_q <= '0;
				sum_q <= '0;
			end else begin
				wp_q  <= next_wp;
				cnt_q <= next_cnt;
				sum_q <= next_sum;
			end
		end
	end

	// Hold the accepted request for the update cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= request.command;
			sample_s1 <= request.sample;
		end
	end

	`BMA_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(WINDOW))
	`BMA_ASSERT_IMP(a_wp_tracks_cnt, clk, arst_n, filling, wp_q == cnt_q[PW-1:0])
	`BMA_ASSERT_NXT(a_accept_push, clk, arst_n, accept, push)

endmodule

[hw/rtl/bma_queue.sv]
// Short FIFO between the front and back parts, carrying sum and count.
// Depends on bma_pkg and the assertion macro header.
`include "boxcar_moving_average_unit_macros.svh"

module bma_queue #(
	parameter int WIDTH = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] dout
);

	localparam int QPW = $clog2(bma_pkg::QUEUE_DEPTH);
	localparam int QCW = $clog2(bma_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] data_q [bma_pkg::QUEUE_DEPTH];
	logic [QPW-1:0]   wr_q;
	logic [QPW-1:0]   rd_q;
	logic [QCW-1:0]   count_q;

	assign full  = count_q == QCW'(bma_pkg::QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign dout  = data_q[rd_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPW'(bma_pkg::QUEUE_DEPTH - 1)) ? '0 : (wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPW'(bma_pkg::QUEUE_DEPTH - 1)) ? '0 : (rd_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= din;
		end
	end

	`BMA_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full)
	`BMA_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, valid)

endmodule

[hw/rtl/bma_back.sv]
// Back part: divides sum by count one quotient bit a cycle and holds the result.
// Depends on bma_pkg, bma_if and the assertion macro header.
`include "boxcar_moving_average_unit_macros.svh"

module bma_back #(
	parameter int WINDOW = bma_pkg::WINDOW_DEF,
	parameter int SUMW   = 20,
	parameter int CW     = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  logic signed [SUMW-1:0] q_sum,
	input  logic [CW-1:0]          q_cnt,
	output logic                   pop,
	bma_out_if.source              result
);

	localparam int DW = SUMW + bma_pkg::FRAC_BITS;
	localparam int SW = $clog2(DW);

	bma_pkg::back_state_t state_q, state_d;

	logic [SW-1:0]          step_q;
	logic [CW:0]            rem_q;
	logic [DW-1:0]          work_q;
	logic [CW-1:0]          div_q;
	logic                   neg_q;
	logic signed [SUMW-1:0] sum_q;
	logic                   out_valid_q;

	logic [SUMW-1:0]        mag;
	logic [CW:0]            rem_sh;
	logic                   ge;
	logic [CW:0]            rem_n;
	logic signed [DW:0]     quot;
	logic [DW+bma_pkg::AVG_W:0]          avg_ext;
	logic [SUMW+bma_pkg::SUM_OUT_W-1:0]  sum_ext;
	logic [CW+bma_pkg::CNT_OUT_W-1:0]    cnt_ext;
	logic                   load;
	logic                   last_step;

	// Magnitude of the incoming sum
	assign mag = q_sum[SUMW-1] ? (~q_sum + 1'b1) : q_sum;

	// One restoring divide step
	assign rem_sh    = {rem_q[CW-1:0], work_q[DW-1]};
	assign ge        = rem_sh >= {1'b0, div_q};
	assign rem_n     = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	assign last_step = step_q == SW'(DW - 1);

	// Apply sign and fit result fields
	assign quot    = neg_q ? -$signed({1'b0, work_q}) : $signed({1'b0, work_q});
	assign avg_ext = {{bma_pkg::AVG_W{quot[DW]}}, quot};
	assign sum_ext = {{bma_pkg::SUM_OUT_W{sum_q[SUMW-1]}}, sum_q};
	assign cnt_ext = {{bma_pkg::CNT_OUT_W{1'b0}}, div_q};

	assign pop  = (state_q == bma_pkg::B_IDLE) && q_valid;
	assign load = (state_q == bma_pkg::B_HOLD) && (!out_valid_q || result.ready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bma_pkg::B_IDLE: begin
				if (q_valid) begin
					state_d = (q_cnt == '0) ? bma_pkg::B_HOLD : bma_pkg::B_DIV;
				end
			end
			bma_pkg::B_DIV: begin
				if (last_step) begin
					state_d = bma_pkg::B_HOLD;
				end
			end
			bma_pkg::B_HOLD: begin
				if (load) begin
					state_d = bma_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = bma_pkg::B_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bma_pkg::B_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				step_q <= '0;
			end else if (state_q == bma_pkg::B_DIV) begin
				step_q <= step_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Divider datapath and result register
	always_ff @(posedge clk) begin
		if (pop) begin
			sum_q  <= q_sum;
			div_q  <= q_cnt;
			neg_q  <= q_sum[SUMW-1];
			work_q <= {mag, {bma_pkg::FRAC_BITS{1'b0}}};
			rem_q  <= '0;
		end else if (state_q == bma_pkg::B_DIV) begin
			rem_q  <= rem_n;
			work_q <= {work_q[DW-2:0], ge};
		end
		if (load) begin
			result.average     <= avg_ext[bma_pkg::AVG_W-1:0];
			result.window_sum  <= sum_ext[bma_pkg::SUM_OUT_W-1:0];
			result.fill_count  <= cnt_ext[bma_pkg::CNT_OUT_W-1:0];
			result.window_full <= div_q == CW'(WINDOW);
		end
	end

	assign result.valid = out_valid_q;

	`BMA_ASSERT_IMP(a_div_nonzero, clk, arst_n, state_q == bma_pkg::B_DIV, div_q != '0)
	`BMA_ASSERT_IMP(a_load_slot_free, clk, arst_n, load && out_valid_q, result.ready)

endmodule
